[rtl/packed_rgb444_line_and_box_raster_unit_defines.svh]
// assertion helpers shared by the raster unit rtl
`ifndef PACKED_RGB444_LINE_AND_BOX_RASTER_UNIT_DEFINES_SVH
`define PACKED_RGB444_LINE_AND_BOX_RASTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PRBL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("raster unit assertion failed");
`define PRBL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("raster unit assertion failed");
`else
`define PRBL_ASSERT_NOW(name, ante, cons)
`define PRBL_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[rtl/prbl_pkg.sv]
package prbl_pkg;

    localparam int FRAME_COLUMNS_DEF    = 110;
    localparam int FRAME_ROWS_DEF       = 110;
    localparam int BYTES_PER_COLUMN_DEF = 165;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 7;
    localparam int NIB_W   = 4;
    localparam int RCOL_W  = 7;
    localparam int RROW_W  = 8;
    localparam int DATA_W  = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BOX   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LINE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_NEXT,
        S_RD,
        S_WR,
        S_RADDR,
        S_RMEM,
        S_RFIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        W_IDLE,
        W_BOX,
        W_LINE
    } t_walk_state;

    typedef struct packed {
        logic start;
        logic box;
        logic advance;
    } t_walk_ctl;

endpackage

[rtl/prbl_walk.sv]
module prbl_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prbl_pkg::t_walk_ctl           i_ctl,
    input  logic [prbl_pkg::COORD_W-1:0]  i_x_start,
    input  logic [prbl_pkg::COORD_W-1:0]  i_y_start,
    input  logic [prbl_pkg::COORD_W-1:0]  i_x_end,
    input  logic [prbl_pkg::COORD_W-1:0]  i_y_end,
    output logic                          o_busy,
    output logic [prbl_pkg::COORD_W-1:0]  o_x,
    output logic [prbl_pkg::COORD_W-1:0]  o_y
);
    import prbl_pkg::*;

    localparam int ERR_W = COORD_W + 3;

    t_walk_state              r_state, n_state;
    logic [COORD_W-1:0]       r_x, n_x;
    logic [COORD_W-1:0]       r_y, n_y;
    logic [COORD_W-1:0]       r_xe, n_xe;
    logic [COORD_W-1:0]       r_ye, n_ye;
    logic [COORD_W-1:0]       r_y0, n_y0;
    logic [COORD_W-1:0]       r_dx, n_dx;
    logic [COORD_W-1:0]       r_dy, n_dy;
    logic                     r_sx_neg, n_sx_neg;
    logic                     r_sy_neg, n_sy_neg;
    logic signed [ERR_W-1:0]  r_err, n_err;

    logic [COORD_W-1:0]       w_dx, w_dy;
    logic [COORD_W-1:0]       w_x_lo, w_x_hi, w_y_lo, w_y_hi;
    logic signed [ERR_W:0]    w_e2, w_dx_s, w_dy_s;
    logic signed [ERR_W-1:0]  w_dx_e, w_dy_e;
    logic                     w_step_x, w_step_y;
    logic [COORD_W:0]         w_x_inc, w_y_inc;

    assign w_dx   = (i_x_end > i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign w_dy   = (i_y_end > i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
    assign w_x_lo = (i_x_start < i_x_end) ? i_x_start : i_x_end;
    assign w_x_hi = (i_x_start < i_x_end) ? i_x_end : i_x_start;
    assign w_y_lo = (i_y_start < i_y_end) ? i_y_start : i_y_end;
    assign w_y_hi = (i_y_start < i_y_end) ? i_y_end : i_y_start;

    // bresenham decision on doubled error
    assign w_e2     = {r_err, 1'b0};
    assign w_dx_s   = $signed((ERR_W+1)'(r_dx));
    assign w_dy_s   = $signed((ERR_W+1)'(r_dy));
    assign w_dx_e   = $signed(ERR_W'(r_dx));
    assign w_dy_e   = $signed(ERR_W'(r_dy));
    assign w_step_x = w_e2 > -w_dy_s;
    assign w_step_y = w_e2 < w_dx_s;

    assign w_x_inc = {1'b0, r_x} + (COORD_W+1)'(1);
    assign w_y_inc = {1'b0, r_y} + (COORD_W+1)'(1);

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_xe     = r_xe;
        n_ye     = r_ye;
        n_y0     = r_y0;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        if (i_ctl.start) begin
            if (i_ctl.box) begin
                n_x  = w_x_lo;
                n_y  = w_y_lo;
                n_y0 = w_y_lo;
                n_xe = w_x_hi;
                n_ye = w_y_hi;
                // empty box draws nothing
                if (i_x_start == i_x_end || i_y_start == i_y_end) begin
                    n_state = W_IDLE;
                end else begin
                    n_state = W_BOX;
                end
            end else begin
                n_x      = i_x_start;
                n_y      = i_y_start;
                n_xe     = i_x_end;
                n_ye     = i_y_end;
                n_dx     = w_dx;
                n_dy     = w_dy;
                n_sx_neg = !(i_x_start < i_x_end);
                n_sy_neg = !(i_y_start < i_y_end);
                n_err    = $signed(ERR_W'(w_dx)) - $signed(ERR_W'(w_dy));
                n_state  = W_LINE;
            end
        end else if (i_ctl.advance) begin
            case (r_state)
                W_BOX: begin
                    if (w_y_inc == {1'b0, r_ye}) begin
                        n_y = r_y0;
                        if (w_x_inc == {1'b0, r_xe}) begin
                            n_state = W_IDLE;
                        end else begin
                            n_x = w_x_inc[COORD_W-1:0];
                        end
                    end else begin
                        n_y = w_y_inc[COORD_W-1:0];
                    end
                end
                W_LINE: begin
                    if (r_x == r_xe && r_y == r_ye) begin
                        n_state = W_IDLE;
                    end else begin
                        n_err = r_err - (w_step_x ? w_dy_e : '0) + (w_step_y ? w_dx_e : '0);
                        if (w_step_x) begin
                            n_x = r_sx_neg ? r_x - COORD_W'(1) : r_x + COORD_W'(1);
                        end
                        if (w_step_y) begin
                            n_y = r_sy_neg ? r_y - COORD_W'(1) : r_y + COORD_W'(1);
                        end
                    end
                end
                default: begin
                    n_state = W_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_xe     <= n_xe;
        r_ye     <= n_ye;
        r_y0     <= n_y0;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sx_neg <= n_sx_neg;
        r_sy_neg <= n_sy_neg;
        r_err    <= n_err;
    end

    assign o_busy = (r_state != W_IDLE);
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

[rtl/packed_rgb444_line_and_box_raster_unit.sv]
// packed rgb444 raster unit: one command item in, one result item out.
// input channel: i_in_valid / o_in_stall with command, box or line corners,
// color nibbles and a read address. output channel: o_out_valid / i_out_stall
// with read_data (stored byte for a read, else zero) and clipped.
// the frame store is one byte-wide synchronous ram; each drawn pixel costs
// a read-modify-write (address, read plus full-byte write, merged write).
// clear sweeps the store one byte per cycle, FRAME_COLUMNS*BYTES_PER_COLUMN
// bytes in all (18150 by default). one item is worked at a time; o_in_stall
// is high while it is in flight. after reset the same clearing sweep runs
// with o_in_stall high, and no result is produced for it.
// a finished result sits in the output register until the receiver drops
// i_out_stall; meanwhile the next item is accepted and worked, and it holds
// its own result back until the register is free.
`include "packed_rgb444_line_and_box_raster_unit_defines.svh"

module packed_rgb444_line_and_box_raster_unit #(
    parameter int FRAME_COLUMNS    = prbl_pkg::FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS       = prbl_pkg::FRAME_ROWS_DEF,
    parameter int BYTES_PER_COLUMN = prbl_pkg::BYTES_PER_COLUMN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [prbl_pkg::CMD_W-1:0]   i_command,
    input  logic [prbl_pkg::COORD_W-1:0] i_x_start,
    input  logic [prbl_pkg::COORD_W-1:0] i_y_start,
    input  logic [prbl_pkg::COORD_W-1:0] i_x_end,
    input  logic [prbl_pkg::COORD_W-1:0] i_y_end,
    input  logic [prbl_pkg::NIB_W-1:0]   i_red,
    input  logic [prbl_pkg::NIB_W-1:0]   i_green,
    input  logic [prbl_pkg::NIB_W-1:0]   i_blue,
    input  logic [prbl_pkg::RCOL_W-1:0]  i_read_column,
    input  logic [prbl_pkg::RROW_W-1:0]  i_read_row,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [prbl_pkg::DATA_W-1:0]  o_read_data,
    output logic                         o_clipped
);
    import prbl_pkg::*;

    localparam int DEPTH  = FRAME_COLUMNS * BYTES_PER_COLUMN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_odd, n_odd;
    logic                r_clip, n_clip;
    logic [DATA_W-1:0]   r_rdat, n_rdat;
    logic                r_clr_cmd, n_clr_cmd;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_clip, n_out_clip;

    logic [CMD_W-1:0]    r_cmd;
    logic [COORD_W-1:0]  r_xs, r_ys, r_xe, r_ye;
    logic [NIB_W-1:0]    r_red, r_grn, r_blu;
    logic [RCOL_W-1:0]   r_rcol;
    logic [RROW_W-1:0]   r_rrow;

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [DATA_W-1:0]   r_rdata;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_mem_waddr, w_mem_raddr;
    logic [DATA_W-1:0]   w_mem_wdata;

    t_walk_ctl           w_wctl;
    logic                w_wbusy;
    logic [COORD_W-1:0]  w_wx, w_wy, w_wxe, w_wye;

    logic [COORD_W+1:0]  w_y3;
    logic [COORD_W:0]    w_lo;
    logic [COORD_W+1:0]  w_lo_nx;
    logic                w_pix_clip, w_rd_out;
    logic [ADDR_W-1:0]   w_addr_nx, w_addr_rmw, w_addr_full;

    // a single pixel is a line from a point to itself
    assign w_wxe = (r_cmd == CMD_PIXEL) ? r_xs : r_xe;
    assign w_wye = (r_cmd == CMD_PIXEL) ? r_ys : r_ye;

    prbl_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_wctl),
        .i_x_start (r_xs),
        .i_y_start (r_ys),
        .i_x_end   (w_wxe),
        .i_y_end   (w_wye),
        .o_busy    (w_wbusy),
        .o_x       (w_wx),
        .o_y       (w_wy)
    );

    // byte holding nibble 3*y, and the byte after it
    assign w_y3       = {2'b00, w_wy} + {1'b0, w_wy, 1'b0};
    assign w_lo       = w_y3[COORD_W+1:1];
    assign w_lo_nx    = {1'b0, w_lo} + (COORD_W+2)'(1);
    assign w_pix_clip = (w_wx >= FRAME_COLUMNS) || (w_wy >= FRAME_ROWS) ||
                        (w_lo_nx >= BYTES_PER_COLUMN);
    assign w_rd_out   = (r_rcol >= FRAME_COLUMNS) || (r_rrow >= BYTES_PER_COLUMN);

    assign w_addr_nx   = r_addr + ADDR_W'(1);
    assign w_addr_rmw  = r_odd ? r_addr : w_addr_nx;
    assign w_addr_full = r_odd ? w_addr_nx : r_addr;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_odd       = r_odd;
        n_clip      = r_clip;
        n_rdat      = r_rdat;
        n_clr_cmd   = r_clr_cmd;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_clip  = r_out_clip;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = '0;
        w_mem_raddr = r_addr;
        w_wctl      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_cnt;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_clip    = 1'b0;
                n_rdat    = '0;
                n_clr_cmd = 1'b0;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_clr_cmd = 1'b1;
                        n_state   = S_CLEAR;
                    end
                    CMD_PIXEL, CMD_LINE: begin
                        w_wctl.start = 1'b1;
                        n_state      = S_NEXT;
                    end
                    CMD_BOX: begin
                        w_wctl.start = 1'b1;
                        w_wctl.box   = 1'b1;
                        n_state      = S_NEXT;
                    end
                    CMD_READ: begin
                        n_state = S_RADDR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NEXT: begin
                if (!w_wbusy) begin
                    n_state = S_DONE;
                end else begin
                    w_wctl.advance = 1'b1;
                    if (w_pix_clip) begin
                        n_clip = 1'b1;
                    end else begin
                        n_addr  = ADDR_W'(w_wx * BYTES_PER_COLUMN) + ADDR_W'(w_lo);
                        n_odd   = w_wy[0];
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // fetch the shared byte, overwrite the byte owned by this pixel
                w_mem_raddr = w_addr_rmw;
                w_mem_we    = 1'b1;
                w_mem_waddr = w_addr_full;
                w_mem_wdata = r_odd ? {r_blu, r_grn} : {r_grn, r_red};
                n_state     = S_WR;
            end
            S_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_addr_rmw;
                w_mem_wdata = r_odd ? {r_red, r_rdata[NIB_W-1:0]}
                                    : {r_rdata[DATA_W-1:NIB_W], r_blu};
                n_state     = S_NEXT;
            end
            S_RADDR: begin
                if (w_rd_out) begin
                    n_clip  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_addr  = ADDR_W'(r_rcol * BYTES_PER_COLUMN) + ADDR_W'(r_rrow);
                    n_state = S_RMEM;
                end
            end
            S_RMEM: begin
                n_state = S_RFIN;
            end
            S_RFIN: begin
                n_rdat  = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rdat;
                    n_out_clip  = r_clip;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_cmd   <= 1'b0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clr_cmd   <= n_clr_cmd;
            r_clip      <= n_clip;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_odd      <= n_odd;
        r_rdat     <= n_rdat;
        r_out_data <= n_out_data;
        r_out_clip <= n_out_clip;
        if (i_in_valid && !o_in_stall) begin
            r_cmd  <= i_command;
            r_xs   <= i_x_start;
            r_ys   <= i_y_start;
            r_xe   <= i_x_end;
            r_ye   <= i_y_end;
            r_red  <= i_red;
            r_grn  <= i_green;
            r_blu  <= i_blue;
            r_rcol <= i_read_column;
            r_rrow <= i_read_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_mem_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_clipped   = r_out_clip;

    `PRBL_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == S_START)
    `PRBL_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state == S_DONE))
    `PRBL_ASSERT_NOW(a_rmw_ports_apart, r_state == S_RD, w_mem_raddr != w_mem_waddr)
    `PRBL_ASSERT_NOW(a_done_walker_idle, r_state == S_DONE, !w_wbusy)

endmodule
